// ----- sv/gcds_pkg.sv -----
// Shared constants, types and helper functions for the grid cell distance sorter.
// No dependencies; imported by every module of the block.
package gcds_pkg;

  // Grid shape and mask geometry
  localparam int GRID_ROWS = 6;
  localparam int GRID_COLS = 4;
  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int MASK_W = 24;
  localparam int LIST_DEPTH = (CELLS < MASK_W) ? CELLS : MASK_W;

  // Field widths
  localparam int COORD_W = 14;
  localparam int DIST_W = 23;
  localparam int COL_W = 2;
  localparam int ROW_W = 3;
  localparam int RC_W = 3;
  localparam int SQ_W = 2 * COORD_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int IDX_W = $clog2(CELLS + 1);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  // Stream payload widths
  localparam int IN_W = 56;
  localparam int OUT_W = 32;
  localparam int OUT_USED_W = COL_W + ROW_W + DIST_W;

  // Cell centre geometry
  localparam int CELL_PITCH = 16;
  localparam int X_OFFSET = 12;
  localparam int Y_OFFSET = 16;
  localparam int SCALE = 64;
  localparam int SCALE_SHIFT = 6;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic diff;
    logic square;
    logic insert;
    logic pop;
    logic show_none;
    logic [IDX_W-1:0] idx;
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic visible;
    logic [CNT_W-1:0] count;
  } status_t;

  // World x coordinate of a column's centre
  function automatic logic [COORD_W-1:0] centre_x(input logic [RC_W-1:0] col);
    centre_x = COORD_W'((int'(col) * CELL_PITCH + X_OFFSET) * SCALE);
  endfunction

  // World y coordinate of a row's centre
  function automatic logic [COORD_W-1:0] centre_y(input logic [RC_W-1:0] row);
    centre_y = COORD_W'((int'(row) * CELL_PITCH + Y_OFFSET) * SCALE);
  endfunction

  // Absolute difference of two coordinates
  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- sv/gcds_datapath.sv -----
// Datapath of the grid cell distance sorter: request registers, distance
// pipeline and the sorted insertion list. Depends on gcds_pkg.
module gcds_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  gcds_pkg::cmd_t                 cmd,
  input  logic [gcds_pkg::COORD_W-1:0]   camera_x,
  input  logic [gcds_pkg::COORD_W-1:0]   camera_y,
  input  logic [gcds_pkg::MASK_W-1:0]    visible_mask,
  output gcds_pkg::status_t              status,
  output logic [gcds_pkg::COL_W-1:0]     cell_column,
  output logic [gcds_pkg::ROW_W-1:0]     cell_row,
  output logic [gcds_pkg::DIST_W-1:0]    distance,
  output logic                           last,
  output logic                           none
);
  import gcds_pkg::*;

  logic [COORD_W-1:0] cam_x;
  logic [COORD_W-1:0] cam_y;
  logic [MASK_W-1:0]  mask;
  logic [MASK_W-1:0]  mask_shifted;
  logic [COORD_W-1:0] adx;
  logic [COORD_W-1:0] ady;
  logic [SQ_W-1:0]    sqx;
  logic [SQ_W-1:0]    sqy;
  logic [RC_W-1:0]    cur_row;
  logic [RC_W-1:0]    cur_col;
  logic [SUM_W-1:0]   sum;
  logic [DIST_W-1:0]  new_dist;

  logic [DIST_W-1:0]     slot_dist [LIST_DEPTH];
  logic [RC_W-1:0]       slot_row  [LIST_DEPTH];
  logic [RC_W-1:0]       slot_col  [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] slot_valid;
  logic [LIST_DEPTH-1:0] gt;
  logic [CNT_W-1:0]      count;

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cam_x <= camera_x;
      cam_y <= camera_y;
      mask  <= visible_mask;
    end
  end

  // Mask bit of the cell under scan; bits past the mask width read as zero
  assign mask_shifted = mask >> cmd.idx;
  assign status.visible = mask_shifted[0];
  assign status.count = count;

  // Distance pipeline: differences, then squares, then the scaled sum
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      adx     <= abs_diff(cam_x, centre_x(cmd.col));
      ady     <= abs_diff(cam_y, centre_y(cmd.row));
      cur_row <= cmd.row;
      cur_col <= cmd.col;
    end
    if (cmd.square) begin
      sqx <= adx * adx;
      sqy <= ady * ady;
    end
  end

  assign sum = SUM_W'(sqx) + SUM_W'(sqy);
  assign new_dist = DIST_W'(sum >> SCALE_SHIFT);

  // Slot is displaced by the new entry when empty or strictly farther
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      gt[i] = !slot_valid[i] || (slot_dist[i] > new_dist);
    end
  end

  // Insert keeps the list sorted; pop moves every entry one place toward the head
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.insert && gt[i]) begin
        if (i != 0 && gt[(i == 0) ? 0 : i - 1]) begin
          slot_dist[i] <= slot_dist[(i == 0) ? 0 : i - 1];
          slot_row[i]  <= slot_row[(i == 0) ? 0 : i - 1];
          slot_col[i]  <= slot_col[(i == 0) ? 0 : i - 1];
        end else begin
          slot_dist[i] <= new_dist;
          slot_row[i]  <= cur_row;
          slot_col[i]  <= cur_col;
        end
      end else if (cmd.pop && i != LIST_DEPTH - 1) begin
        slot_dist[i] <= slot_dist[(i == LIST_DEPTH - 1) ? i : i + 1];
        slot_row[i]  <= slot_row[(i == LIST_DEPTH - 1) ? i : i + 1];
        slot_col[i]  <= slot_col[(i == LIST_DEPTH - 1) ? i : i + 1];
      end
    end
  end

  // Occupancy: valid entries always sit contiguously from the head
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      slot_valid <= '0;
      count      <= '0;
    end else if (cmd.insert) begin
      slot_valid <= (slot_valid << 1) | LIST_DEPTH'(1);
      count      <= count + CNT_W'(1);
    end else if (cmd.pop) begin
      slot_valid <= slot_valid >> 1;
      count      <= count - CNT_W'(1);
    end
  end

  // Result fields from the list head; all zero for an empty request
  assign cell_column = cmd.show_none ? '0 : slot_col[0][COL_W-1:0];
  assign cell_row    = cmd.show_none ? '0 : slot_row[0][ROW_W-1:0];
  assign distance    = cmd.show_none ? '0 : slot_dist[0];
  assign last        = !cmd.show_none && (count == CNT_W'(1));
  assign none        = cmd.show_none;

endmodule

// ----- sv/gcds_ctrl.sv -----
// Controller of the grid cell distance sorter: scans the grid, sequences the
// distance pipeline and the list, and runs both stream handshakes. Depends on gcds_pkg.
module gcds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  output logic              m_valid,
  input  logic              m_ready,
  input  gcds_pkg::status_t status,
  output gcds_pkg::cmd_t    cmd
);
  import gcds_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_INS  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;
  localparam logic [2:0] ST_NONE = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [IDX_W-1:0] idx;
  logic [RC_W-1:0]  row;
  logic [RC_W-1:0]  col;
  logic             advance;
  logic             last_cell;

  assign last_cell = (idx == IDX_W'(CELLS - 1));
  assign advance = ((state == ST_SCAN) && !status.visible) || (state == ST_INS);

  // Handshakes and datapath commands
  assign s_ready = (state == ST_IDLE);
  assign m_valid = (state == ST_EMIT) || (state == ST_NONE);

  always_comb begin
    cmd.load      = (state == ST_IDLE) && s_valid;
    cmd.diff      = (state == ST_SCAN) && status.visible;
    cmd.square    = (state == ST_SQR);
    cmd.insert    = (state == ST_INS);
    cmd.pop       = (state == ST_EMIT) && m_ready;
    cmd.show_none = (state == ST_NONE);
    cmd.idx       = idx;
    cmd.row       = row;
    cmd.col       = col;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.visible) state_next = ST_SQR;
        else if (last_cell) state_next = ST_FIN;
      end
      ST_SQR:  state_next = ST_INS;
      ST_INS:  state_next = last_cell ? ST_FIN : ST_SCAN;
      ST_FIN:  state_next = (status.count == '0) ? ST_NONE : ST_EMIT;
      ST_EMIT: if (m_ready && status.count == CNT_W'(1)) state_next = ST_IDLE;
      ST_NONE: if (m_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Row-major scan position
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      idx <= '0;
      row <= '0;
      col <= '0;
    end else if (advance && !last_cell) begin
      idx <= idx + IDX_W'(1);
      if (col == RC_W'(GRID_COLS - 1)) begin
        col <= '0;
        row <= row + RC_W'(1);
      end else begin
        col <= col + RC_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.diff, cmd.square, cmd.insert, cmd.pop, cmd.show_none}))
    else $error("datapath commands overlap");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> (status.count < CNT_W'(LIST_DEPTH)))
    else $error("insert into a full list");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (status.count != '0))
    else $error("emitting from an empty list");

  a_square_after_diff: assert property (@(posedge clk) disable iff (rst)
    cmd.diff |=> cmd.square)
    else $error("square step did not follow difference step");
`endif

endmodule

// ----- sv/grid_cell_distance_sorter.sv -----
// Grid cell distance sorter top level: stream ports, payload packing, and the
// controller and datapath instances. Depends on gcds_pkg, gcds_ctrl, gcds_datapath.
//
// One request (camera x, y and a 24-bit visibility mask over the 6x4 grid) is
// accepted when the block is idle. The controller scans all 24 cells in row-major
// order; each visible cell then passes through the single squaring stage and is
// inserted into a 24-entry sorted list in which each slot compares its distance
// with the new one. After a finishing state the list is streamed out nearest first,
// one result per cycle while the sink is ready, with tlast on the final one; an
// empty mask yields a single result with tuser set. A request is scanned, inserted
// one cell at a time and fully streamed out before the next one is accepted.
module grid_cell_distance_sorter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // camera_x[13:0], camera_y[27:14], visible_mask[51:28], zero pad
  input  logic [gcds_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // cell_column[1:0], cell_row[4:2], distance[27:5], zero pad
  output logic [gcds_pkg::OUT_W-1:0]   m_axis_tdata,
  output logic                         m_axis_tlast,
  // none[0]
  output logic                         m_axis_tuser
);
  import gcds_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic [COL_W-1:0]   cell_column;
  logic [ROW_W-1:0]   cell_row;
  logic [DIST_W-1:0]  distance;

  gcds_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  gcds_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .camera_x     (s_axis_tdata[COORD_W-1:0]),
    .camera_y     (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .visible_mask (s_axis_tdata[2*COORD_W+MASK_W-1:2*COORD_W]),
    .status       (status),
    .cell_column  (cell_column),
    .cell_row     (cell_row),
    .distance     (distance),
    .last         (m_axis_tlast),
    .none         (m_axis_tuser)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = {{(OUT_W - OUT_USED_W){1'b0}}, distance, cell_row, cell_column};

endmodule
